[design/stm_pkg.sv]
// Package for the shader text minifier: request types, judge state and
// character codes. No dependencies; imported by shader_text_minifier.
package stm_pkg;

    // Result buffer depth: one item can release up to seven results
    localparam int MAX_RES = 8;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // Input request
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // Output request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_output;
    } t_out;

    // Judge state; h0 is the held-back newest output byte, h1 the one before
    typedef struct packed {
        logic       line_cmt;
        logic       blk_cmt;
        logic       in_dir;
        logic       squeeze;
        logic [7:0] prev;
        logic       h0_v;
        logic [7:0] h0;
        logic       h1_v;
        logic [7:0] h1;
    } t_mstate;

    localparam t_mstate ST_RESET = '{
        line_cmt: 1'b0, blk_cmt: 1'b0, in_dir: 1'b0, squeeze: 1'b1,
        prev: 8'h00, h0_v: 1'b0, h0: 8'h00, h1_v: 1'b0, h1: 8'h00
    };

    // Outcome of judging one byte: new state and up to three released bytes
    typedef struct packed {
        t_mstate        st;
        logic [1:0]     cnt;
        logic [2:0][7:0] bytes;
    } t_judge;

endpackage

[design/shader_text_minifier.sv]
// Shader text minifier top level: input register, single-pass byte judge
// and result shift buffer. Depends on stm_pkg.
//
// Usage: source text enters one byte per request on the input channel
// (i_in_valid / o_in_stall, payload i_in_data), end_of_text set on the
// final byte. Minified bytes leave on the output channel (o_out_valid /
// i_out_stall, payload o_out_data), end_of_output set on the final result;
// a text that yields no bytes gives one result with byte_valid low.
// Sequence: a byte is registered, then judged when the following byte (or the
// end flag) is known, and the newest output byte is held back one step so a
// space before an operator can be dropped. Results are loaded into the
// result buffer as the judging item leaves the input register.
// Throughput: one byte per cycle while each item releases at most one
// result and i_out_stall is low. An item that releases k results (up to
// seven on the final byte) drains one per unstalled cycle; the input
// register holds the next byte until the last of them is taken.
// Stall on the output holds the buffer head stable and backs up into
// o_in_stall once the input register is full.
// Reset (synchronous, active low) empties both registers and returns the
// judge to its start state; after each final byte it returns there too.
module shader_text_minifier
    import stm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // ---------------------------------------------------------------
    // Character classes
    function automatic logic f_blank(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    function automatic logic f_retract_op(logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_SEMI,
                         CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC, CH_COMMA,
                         CH_BAR, CH_AMP, CH_LT, CH_GT};
    endfunction

    function automatic logic f_squeeze_op(logic [7:0] c);
        return f_retract_op(c) || f_blank(c) || c == CH_LBRK || c == CH_RBRK;
    endfunction

    // Push a byte into the history; the held head is released unless it
    // was just retracted (then the head is simply replaced)
    function automatic t_judge f_push(t_judge j, logic [7:0] b, logic retract);
        t_judge r;
        r = j;
        if (!retract) begin
            if (j.st.h0_v) begin
                r.bytes[j.cnt] = j.st.h0;
                r.cnt          = j.cnt + 2'd1;
            end
            r.st.h1_v = j.st.h0_v;
            r.st.h1   = j.st.h0;
        end
        r.st.h0_v = 1'b1;
        r.st.h0   = b;
        return r;
    endfunction

    // Judge one source byte, with the following byte when there is one
    function automatic t_judge f_judge(t_mstate s, logic [7:0] c,
                                       logic [7:0] nx, logic nx_v);
        t_judge j;
        logic   sq_new;
        logic   retract;
        j.st      = s;
        j.st.prev = c;
        j.cnt     = 2'd0;
        j.bytes   = '0;
        sq_new    = f_squeeze_op(c);
        retract   = sq_new && s.h0_v && s.h0 == CH_SPACE && f_retract_op(c);
        if (s.blk_cmt) begin
            if (c == CH_SLASH && s.prev == CH_STAR) j.st.blk_cmt = 1'b0;
        end else if (s.in_dir) begin
            if (c == CH_LF) begin
                j = f_push(j, CH_BSL, 1'b0);
                j = f_push(j, CH_N, 1'b0);
                j.st.in_dir  = 1'b0;
                j.st.squeeze = 1'b1;
            end else begin
                j = f_push(j, c, 1'b0);
            end
        end else if (s.line_cmt) begin
            if (c == CH_LF) j.st.line_cmt = 1'b0;
        end else if (c == CH_SLASH && nx_v && nx == CH_SLASH) begin
            j.st.line_cmt = 1'b1;
        end else if (c == CH_SLASH && nx_v && nx == CH_STAR) begin
            j.st.blk_cmt = 1'b1;
        end else begin
            // '#' opens a directive, escaped unless one already precedes it or fewer than two bytes are held
            if (c == CH_HASH) begin
                if (s.h0_v && s.h1_v && !(s.h1 == CH_BSL && s.h0 == CH_N)) begin
                    j = f_push(j, CH_BSL, 1'b0);
                    j = f_push(j, CH_N, 1'b0);
                    // escape pushed: retraction test sees 'n', not a space
                    retract = 1'b0;
                end
                j.st.in_dir = 1'b1;
            end
            if (!(s.squeeze && f_blank(c))) begin
                j.st.squeeze = sq_new;
                j = f_push(j, (c == CH_CR || c == CH_LF) ? CH_SPACE : c, retract);
            end
        end
        return j;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    logic       r_in_v;
    t_in        r_in;
    t_mstate    r_st;
    logic       r_look_v;
    logic [7:0] r_look;
    t_out       r_buf [MAX_RES];
    logic [CNT_W-1:0] r_cnt;

    logic       take;
    logic       pop;
    logic       buf_free;
    logic       consume;

    t_judge     j1;
    t_judge     j2;
    t_out       n_list [MAX_RES];
    logic [CNT_W-1:0] n_cnt;
    t_mstate    n_st;
    logic       n_look_v;
    logic [IDX_W-1:0] base2;

    // Handshake
    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign buf_free    = (r_cnt == '0) || (r_cnt == CNT_W'(1) && pop);
    assign consume     = r_in_v && buf_free;
    assign o_in_stall  = r_in_v && !consume;
    assign take        = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];

    // Judge the lookahead byte, then on the final request the byte itself
    always_comb begin
        if (r_look_v) begin
            j1 = f_judge(r_st, r_look, r_in.text_byte, 1'b1);
        end else begin
            j1 = '{st: r_st, cnt: 2'd0, bytes: '0};
        end
        j2    = f_judge(j1.st, r_in.text_byte, 8'h00, 1'b0);
        base2 = IDX_W'(j1.cnt) + IDX_W'(j2.cnt);

        for (int k = 0; k < MAX_RES; k++) begin
            n_list[k] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < j1.cnt) begin
                n_list[IDX_W'(k)] = '{out_byte: j1.bytes[2'(k)], byte_valid: 1'b1,
                                      end_of_output: 1'b0};
            end
        end

        if (r_in.end_of_text) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < j2.cnt) begin
                    n_list[IDX_W'(j1.cnt) + IDX_W'(k)] =
                        '{out_byte: j2.bytes[2'(k)], byte_valid: 1'b1,
                          end_of_output: 1'b0};
                end
            end
            // Held-back byte closes the text, or a bare end marker
            if (j2.st.h0_v) begin
                n_list[base2] = '{out_byte: j2.st.h0, byte_valid: 1'b1,
                                  end_of_output: 1'b1};
            end else begin
                n_list[base2] = '{out_byte: 8'h00, byte_valid: 1'b0,
                                  end_of_output: 1'b1};
            end
            n_cnt    = CNT_W'(base2) + CNT_W'(1);
            n_st     = ST_RESET;
            n_look_v = 1'b0;
        end else begin
            n_cnt    = CNT_W'(j1.cnt);
            n_st     = j1.st;
            n_look_v = 1'b1;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (take) begin
            r_in_v <= 1'b1;
        end else if (consume) begin
            r_in_v <= 1'b0;
        end
        if (take) begin
            r_in <= i_in_data;
        end
    end

    // Judge state and lookahead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_RESET;
            r_look_v <= 1'b0;
            r_look   <= 8'h00;
        end else if (consume) begin
            r_st     <= n_st;
            r_look_v <= n_look_v;
            r_look   <= r_in.text_byte;
        end
    end

    // Result buffer: load a new list when free, else shift out one per pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (consume) begin
            r_cnt <= n_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (consume) begin
            r_buf <= n_list;
        end else if (pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
            r_buf[MAX_RES - 1] <= '0;
        end
    end

`ifndef SYNTHESIS
    // Buffer count never exceeds its depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RES))
        else $error("result count beyond buffer depth");

    // A final byte always leaves at least the closing result
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in.end_of_text |=> r_cnt != '0)
        else $error("final byte produced no result");

    // The closing result is the last one in the buffer
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_output |-> r_cnt == CNT_W'(1))
        else $error("results queued after end of output");

    // A result without a byte is only the bare end marker
    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |-> o_out_data.end_of_output)
        else $error("empty result that is not the end marker");
`endif

endmodule
